@@ hdl/scan_line_frame_store_colorizer_core_defines.svh @@
// assertion macros for the scan line frame store colorizer
// no dependencies; included by the top level, expands to nothing under SYNTHESIS
`ifndef SCAN_LINE_FRAME_STORE_COLORIZER_CORE_DEFINES_SVH
`define SCAN_LINE_FRAME_STORE_COLORIZER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication, clocked on i_clk, off during reset
`define SLFC_ASSERT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("slfc assertion failed");
// next-cycle implication
`define SLFC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("slfc assertion failed");
`else
`define SLFC_ASSERT(lbl, ante, cons)
`define SLFC_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

@@ hdl/slfc_pkg.sv @@
// shared types, codes and constants of the scan line frame store colorizer
// no dependencies
package slfc_pkg;

    localparam int DEF_MAX_WIDTH  = 512;
    localparam int DEF_MAX_HEIGHT = 256;

    // fixed field widths
    localparam int FW_W   = 10;
    localparam int FH_W   = 9;
    localparam int LINE_W = 32;
    localparam int COLF_W = 9;
    localparam int PROW_W = 8;
    localparam int Z_W    = 24;
    localparam int INT_W  = 16;
    localparam int LT_W   = 9;
    localparam int CH_W   = 8;

    localparam logic [FW_W-1:0] FW_RESET = 10'd512;
    localparam logic [FH_W-1:0] FH_RESET = 9'd256;

    typedef enum logic [1:0] {
        OP_WRITE     = 2'd0,
        OP_RD_HEIGHT = 2'd1,
        OP_RD_INTEN  = 2'd2,
        OP_CLEAR     = 2'd3
    } t_opcode;

    typedef enum logic {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } t_reg_idx;

    localparam logic [Z_W-1:0] NO_MEAS_CODE = 24'h800000;

    // height palette: v = 2z + 80000, index = v / 625
    localparam int V_W = 26;
    localparam logic signed [V_W-1:0] V_OFFSET = 26'sd80000;
    localparam logic signed [V_W-1:0] V_LOW    = -26'sd625;
    localparam logic signed [V_W-1:0] V_HIGH   = 26'sd160000;
    localparam int VPOS_W      = 18;
    localparam int RECIP_SHIFT = 27;
    localparam int PROD_W      = 35;
    // ceil(2^27 / 625), exact for v below 160000
    localparam logic [VPOS_W-1:0] RECIP_625 = 18'd214749;

    localparam int NUM_COLORS = 256;
    localparam logic [CH_W-1:0] PAL_BLUE = 8'd50;
    localparam logic [CH_W-1:0] PAL_MAX  = 8'd255;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } t_rgb;

    typedef struct packed {
        logic load;
        logic is_height;
        logic in_frame;
    } t_color_ctl;

    typedef struct packed {
        logic [Z_W-1:0]   z;
        logic [INT_W-1:0] inten;
    } t_pixel_word;

endpackage

@@ hdl/scan_line_frame_store_colorizer_core.sv @@
// top level of the scan line frame store colorizer: control, registers, store
// depends on slfc_pkg, slfc_frame_ram, slfc_colorize and the defines header
//
//  channel  | direction | handshake                 | payload
//  ---------+-----------+---------------------------+-------------------------------
//  in       | input     | i_in_valid / o_in_stall   | opcode, line, column, row, z, i
//  out      | output    | o_out_valid / i_out_stall | accepted, frame_ready, rgb
//  config   | input     | psel/penable/pwrite/pready| frame_width @0, frame_height @4
//
// one word at a time: a write goes S_DECIDE, S_ACCESS, S_DONE, a read adds S_READ
// (store read, then multiply for the /625 palette index), a clear skips to S_DONE
// reset and clear both run a clearing pass over the store, one entry per cycle,
// all MAX_WIDTH*MAX_HEIGHT entries (131072 at default size), input stalled meanwhile
// the output register parts the two sides: a new word is taken while a result waits,
// and the next result waits in its final state until the output register frees up
`include "scan_line_frame_store_colorizer_core_defines.svh"
module scan_line_frame_store_colorizer_core import slfc_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,

    // input words
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic [1:0]               i_opcode,
    input  logic [LINE_W-1:0]        i_line_index,
    input  logic [COLF_W-1:0]        i_column,
    input  logic [PROW_W-1:0]        i_pixel_row,
    input  logic signed [Z_W-1:0]    i_z_sample,
    input  logic [INT_W-1:0]         i_intensity_sample,
    input  logic                     i_last_in_line,

    // result words
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic                     o_accepted,
    output logic                     o_frame_ready,
    output logic [CH_W-1:0]          o_red,
    output logic [CH_W-1:0]          o_green,
    output logic [CH_W-1:0]          o_blue,

    // configuration
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [2:0]               paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);

    localparam int W_EFF_W = $clog2(MAX_WIDTH + 1);
    localparam int H_EFF_W = $clog2(MAX_HEIGHT + 1);
    localparam int ROW_W   = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int COLA_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int DEPTH   = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DECIDE,
        S_ACCESS,
        S_READ,
        S_DONE
    } t_state;

    // configuration registers
    logic [FW_W-1:0]     r_frame_width;
    logic [FH_W-1:0]     r_frame_height;
    logic                cfg_write;

    // control state
    t_state              r_state;
    logic [ADDR_W-1:0]   r_clr_addr;
    logic [LINE_W-1:0]   r_first;
    logic [LT_W-1:0]     r_lines_taken;
    logic                r_ready_flag;

    // captured word
    t_opcode             r_op;
    logic [LINE_W-1:0]   r_line;
    logic [COLF_W-1:0]   r_col;
    logic [PROW_W-1:0]   r_prow;
    logic [Z_W-1:0]      r_z;
    logic [INT_W-1:0]    r_inten;
    logic                r_last;

    // decision results
    logic [ADDR_W-1:0]   r_addr;
    logic                r_do_store;
    logic                r_acc;
    logic                r_in_frame;

    // output register
    logic                r_out_valid;
    logic                r_out_acc;
    logic                r_out_ready;
    t_rgb                r_out_rgb;

    // decide stage logic
    logic [W_EFF_W-1:0]  w_eff;
    logic [H_EFF_W-1:0]  h_eff;
    logic [LINE_W-1:0]   first_eff;
    logic [LINE_W-1:0]   diff;
    logic                neg;
    logic                room;
    logic                beyond;
    logic                col_ok;
    logic                prow_ok;
    logic                wr_take;
    logic                wr_store;
    logic [ROW_W-1:0]    row;
    logic [ADDR_W-1:0]   addr_calc;
    logic                in_fire;
    logic                out_free;
    logic                res_load;
    logic                is_read;

    // store and palette
    logic                ram_we;
    logic [ADDR_W-1:0]   ram_addr;
    t_pixel_word         ram_wdata;
    t_pixel_word         ram_rdata;
    t_color_ctl          color_ctl;
    t_rgb                color_rgb;

    // ---------------------------------------------------------------
    // configuration port, always ready, decoded on paddr[2]
    // ---------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= FW_RESET;
            r_frame_height <= FH_RESET;
        end else if (cfg_write) begin
            unique case (t_reg_idx'(paddr[2]))
                REG_FRAME_WIDTH:  r_frame_width  <= pwdata[FW_W-1:0];
                REG_FRAME_HEIGHT: r_frame_height <= pwdata[FH_W-1:0];
                default:          r_frame_width  <= r_frame_width;
            endcase
        end
    end

    always_comb begin
        unique case (t_reg_idx'(paddr[2]))
            REG_FRAME_WIDTH:  prdata = 32'(r_frame_width);
            REG_FRAME_HEIGHT: prdata = 32'(r_frame_height);
            default:          prdata = '0;
        endcase
    end

    // effective frame size, limited by the store geometry
    assign w_eff = (32'(r_frame_width) < 32'(MAX_WIDTH)) ? W_EFF_W'(r_frame_width)
                                                         : W_EFF_W'(MAX_WIDTH);
    assign h_eff = (32'(r_frame_height) < 32'(MAX_HEIGHT)) ? H_EFF_W'(r_frame_height)
                                                           : H_EFF_W'(MAX_HEIGHT);

    // ---------------------------------------------------------------
    // placement decision for the captured word
    // ---------------------------------------------------------------
    always_comb begin
        // until a line is counted after a clear, the written line defines row zero
        first_eff = (r_lines_taken == '0) ? r_line : r_first;
        diff      = r_line - first_eff;
        neg       = diff[LINE_W-1];
        room      = 32'(r_lines_taken) < 32'(h_eff);
        beyond    = !neg && (diff >= 32'(h_eff));
        col_ok    = 32'(r_col) < 32'(w_eff);
        prow_ok   = 32'(r_prow) < 32'(h_eff);
        wr_take   = (r_op == OP_WRITE) && room && !beyond;
        // lines above the first are counted but have no row in the store
        wr_store  = wr_take && !neg && col_ok;
        row       = (r_op == OP_WRITE) ? diff[ROW_W-1:0] : ROW_W'(r_prow);
        // for stored writes and in-frame reads the result is below DEPTH, so arithmetic modulo 2^ADDR_W is exact
        addr_calc = ADDR_W'(row) * ADDR_W'(w_eff) + ADDR_W'(COLA_W'(r_col));
    end

    assign is_read  = (r_op == OP_RD_HEIGHT) || (r_op == OP_RD_INTEN);
    assign in_fire  = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;
    assign res_load = (r_state == S_DONE) && out_free;

    // ---------------------------------------------------------------
    // sequencer: capture, decide, store access, palette, result
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_CLEAR;
            r_clr_addr    <= '0;
            r_first       <= '0;
            r_lines_taken <= '0;
            r_ready_flag  <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_out_valid <= res_load || (r_out_valid && i_out_stall);
            unique case (r_state)
                S_CLEAR: begin
                    // one store entry back to its reset value per cycle
                    if (r_clr_addr == ADDR_W'(DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                    r_clr_addr <= r_clr_addr + 1'b1;
                end
                S_IDLE: begin
                    if (in_fire) begin
                        r_op    <= t_opcode'(i_opcode);
                        r_line  <= i_line_index;
                        r_col   <= i_column;
                        r_prow  <= i_pixel_row;
                        r_z     <= i_z_sample;
                        r_inten <= i_intensity_sample;
                        r_last  <= i_last_in_line;
                        r_state <= S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    r_addr     <= addr_calc;
                    r_do_store <= wr_store;
                    r_acc      <= wr_take;
                    r_in_frame <= prow_ok && col_ok;
                    if (r_op == OP_WRITE) begin
                        if (r_lines_taken == '0) begin
                            r_first <= r_line;
                        end
                        if (room && beyond) begin
                            r_ready_flag <= 1'b1;
                        end
                        if (wr_take && r_last) begin
                            r_lines_taken <= r_lines_taken + 1'b1;
                        end
                    end
                    if (r_op == OP_CLEAR) begin
                        r_lines_taken <= '0;
                        r_ready_flag  <= 1'b0;
                        r_state       <= S_DONE;
                    end else begin
                        r_state <= S_ACCESS;
                    end
                end
                S_ACCESS: begin
                    r_state <= is_read ? S_READ : S_DONE;
                end
                S_READ: begin
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_acc   <= r_acc && (r_op == OP_WRITE);
                        r_out_ready <= r_ready_flag;
                        r_out_rgb   <= is_read ? color_rgb : '0;
                        r_clr_addr  <= '0;
                        r_state     <= (r_op == OP_CLEAR) ? S_CLEAR : S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall    = (r_state != S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_accepted    = r_out_acc;
    assign o_frame_ready = r_out_ready;
    assign o_red         = r_out_rgb.red;
    assign o_green       = r_out_rgb.green;
    assign o_blue        = r_out_rgb.blue;

    // ---------------------------------------------------------------
    // frame store, sweep has the port during clearing
    // ---------------------------------------------------------------
    always_comb begin
        if (r_state == S_CLEAR) begin
            ram_we          = 1'b1;
            ram_addr        = r_clr_addr;
            ram_wdata.z     = NO_MEAS_CODE;
            ram_wdata.inten = '0;
        end else begin
            ram_we          = (r_state == S_ACCESS) && r_do_store;
            ram_addr        = r_addr;
            ram_wdata.z     = r_z;
            ram_wdata.inten = r_inten;
        end
    end

    slfc_frame_ram #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_frame_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    // read data arrives in S_READ, palette index registered for S_DONE
    assign color_ctl.load      = (r_state == S_READ);
    assign color_ctl.is_height = (r_op == OP_RD_HEIGHT);
    assign color_ctl.in_frame  = r_in_frame;

    slfc_colorize u_colorize (
        .i_clk (i_clk),
        .i_ctl (color_ctl),
        .i_rd  (ram_rdata),
        .o_rgb (color_rgb)
    );

    // ---------------------------------------------------------------
    // checks
    // ---------------------------------------------------------------
    // only one word in flight
    `SLFC_ASSERT_NEXT(a_one_word, in_fire, o_in_stall)
    // a taken sample never carries a colour
    `SLFC_ASSERT(a_acc_black, r_out_valid && r_out_acc, r_out_rgb == '0)
    // a clear result starts the sweep at the first entry
    `SLFC_ASSERT_NEXT(a_sweep, res_load && r_op == OP_CLEAR, r_state == S_CLEAR && r_clr_addr == '0)

endmodule

@@ hdl/slfc_frame_ram.sv @@
// single port frame store memory, registered read data
// depends on slfc_pkg
module slfc_frame_ram import slfc_pkg::*; #(
    parameter int DEPTH  = DEF_MAX_WIDTH * DEF_MAX_HEIGHT,
    parameter int ADDR_W = $clog2(DEF_MAX_WIDTH * DEF_MAX_HEIGHT)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_addr,
    input  t_pixel_word       i_wdata,
    output t_pixel_word       o_rdata
);

    t_pixel_word r_mem [DEPTH];
    t_pixel_word r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/slfc_colorize.sv @@
// palette lookup of one stored pixel: height via v/625, intensity as grey
// depends on slfc_pkg
module slfc_colorize import slfc_pkg::*; (
    input  logic        i_clk,
    input  t_color_ctl  i_ctl,
    input  t_pixel_word i_rd,
    output t_rgb        o_rgb
);

    logic signed [V_W-1:0]    v;
    logic                     v_in_range;
    logic [VPOS_W-1:0]        v_pos;
    logic [PROD_W-1:0]        prod;

    logic                     r_black;
    logic                     r_is_height;
    logic                     r_grey_ok;
    logic [CH_W-1:0]          r_idx;
    logic [CH_W-1:0]          r_grey;

    assign v          = $signed({i_rd.z[Z_W-1], i_rd.z, 1'b0}) + V_OFFSET;
    assign v_in_range = (v > V_LOW) && (v < V_HIGH);
    // small negative v still in range maps to index 0
    assign v_pos      = v[V_W-1] ? '0 : v[VPOS_W-1:0];
    // divide by 625 through the reciprocal
    assign prod       = PROD_W'(v_pos) * PROD_W'(RECIP_625);

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_is_height <= i_ctl.is_height;
            r_black     <= !i_ctl.in_frame || (i_ctl.is_height && !v_in_range);
            r_idx       <= prod[RECIP_SHIFT+CH_W-1:RECIP_SHIFT];
            r_grey_ok   <= i_rd.inten < INT_W'(NUM_COLORS);
            r_grey      <= i_rd.inten[CH_W-1:0];
        end
    end

    always_comb begin
        o_rgb = '0;
        if (!r_black) begin
            if (r_is_height) begin
                if (r_idx != '0) begin
                    o_rgb.red   = PAL_MAX - r_idx;
                    o_rgb.green = r_idx;
                    o_rgb.blue  = PAL_BLUE;
                end
            end else if (r_grey_ok) begin
                o_rgb.red   = r_grey;
                o_rgb.green = r_grey;
                o_rgb.blue  = r_grey;
            end
        end
    end

endmodule
